// ===== rtl/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg
// shared widths, command codes and link types for the write-back lru cache
// ----------------------------------------------------------------------------
package csh_pkg;

    localparam int WAYS_DEF        = 4;
    localparam int SETS_DEF        = 64;
    localparam int BLOCK_BYTES_DEF = 32;
    localparam int ADDR_BITS       = 16;
    localparam int AGE_W           = 32;
    localparam int COUNT_W         = 32;
    localparam int RATE_W          = 7;
    localparam int DATA_W          = 8;
    localparam int CMD_W           = 2;
    localparam int QDEPTH          = 2;

    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRELOAD = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [ADDR_BITS-1:0] address;
        logic [DATA_W-1:0]    write_data;
    } csh_item_t;

    // front queue head toward the back end
    typedef struct packed {
        logic      valid;
        csh_item_t item;
    } csh_fq_t;

    // back end status toward the front
    typedef struct packed {
        logic pop;
        logic clr_done;
    } csh_bk_t;

endpackage

// ===== rtl/csh_req_if.sv =====
// ----------------------------------------------------------------------------
// csh_req_if
// request channel: command, byte address and write byte
// ----------------------------------------------------------------------------
interface csh_req_if;
    logic                             valid;
    logic                             ready;
    logic [csh_pkg::CMD_W-1:0]        cmd;
    logic [csh_pkg::ADDR_BITS-1:0]    address;
    logic [csh_pkg::DATA_W-1:0]       write_data;

    modport source (output valid, cmd, address, write_data, input ready);
    modport sink (input valid, cmd, address, write_data, output ready);
endinterface

// ===== rtl/csh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// csh_rsp_if
// response channel: read byte, hit and write-back flags, counters, miss rate
// ----------------------------------------------------------------------------
interface csh_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [csh_pkg::DATA_W-1:0]      read_data;
    logic                            hit;
    logic                            wrote_back;
    logic [csh_pkg::COUNT_W-1:0]     hits_total;
    logic [csh_pkg::COUNT_W-1:0]     misses_total;
    logic [csh_pkg::RATE_W-1:0]      miss_rate_percent;

    modport source (output valid, read_data, hit, wrote_back, hits_total, misses_total,
                     miss_rate_percent, input ready);
    modport sink (input valid, read_data, hit, wrote_back, hits_total, misses_total,
                   miss_rate_percent, output ready);
endinterface

// ===== rtl/set_assoc_writeback_lru_cache.sv =====
// a hit passes lookup, byte access, the miss rate divider and the response
// register; a preload skips lookup and access; a miss adds refill and tag update,
// and write-back first for a dirty victim, one byte per cycle over single ports
// one access at a time: the next request is popped once the response is loaded
// reset: backing memory and ages are swept to zero, one byte a cycle, over all
// 2^ADDR_BITS addresses (65536) with req.ready low
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// byte-wide set-associative write-back cache with counted lru replacement
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache #(
    parameter int WAYS        = csh_pkg::WAYS_DEF,
    parameter int SETS        = csh_pkg::SETS_DEF,
    parameter int BLOCK_BYTES = csh_pkg::BLOCK_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    csh_req_if.sink   req,
    csh_rsp_if.source rsp
);
    import csh_pkg::*;

    csh_fq_t fq;
    csh_bk_t bk;

    csh_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .bk    (bk),
        .fq    (fq)
    );

    csh_back #(
        .WAYS        (WAYS),
        .SETS        (SETS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .fq    (fq),
        .bk    (bk),
        .rsp   (rsp)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !bk.clr_done |-> !req.ready)
        else $error("request taken during clearing pass");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.miss_rate_percent <= 7'd100)
        else $error("miss rate above 100");

    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> !rsp.wrote_back)
        else $error("write-back reported on a hit");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        bk.pop |-> fq.valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/csh_front.sv =====
// ----------------------------------------------------------------------------
// csh_front
// takes request words into a short queue that feeds the back end
// ----------------------------------------------------------------------------
module csh_front (
    input  logic             clk,
    input  logic             rst_n,
    csh_req_if.sink          req,
    input  csh_pkg::csh_bk_t bk,
    output csh_pkg::csh_fq_t fq
);
    import csh_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    csh_item_t          q_mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign req.ready = (count_reg != CNT_W'(QDEPTH)) && bk.clr_done;
    assign push      = req.valid && req.ready;
    assign pop       = bk.pop && (count_reg != '0);

    assign fq.valid = (count_reg != '0);
    assign fq.item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{cmd: req.cmd, address: req.address,
                                       write_data: req.write_data};
        end
    end

endmodule

// ===== rtl/csh_div.sv =====
// ----------------------------------------------------------------------------
// csh_div
// miss rate unit: misses*100 / (hits+misses), one quotient bit per cycle
// ----------------------------------------------------------------------------
module csh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [csh_pkg::COUNT_W-1:0]   hits,
    input  logic [csh_pkg::COUNT_W-1:0]   misses,
    output logic                          done,
    output logic [csh_pkg::RATE_W-1:0]    rate
);
    import csh_pkg::*;

    localparam int NUM_W = COUNT_W + RATE_W + 1;
    localparam int K_W   = $clog2(RATE_W);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  den_reg, den_next;
    logic [RATE_W-1:0] q_reg, q_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  m_ext, num, trial;

    assign m_ext = NUM_W'(misses);
    assign num   = (m_ext << 6) + (m_ext << 5) + (m_ext << 2);
    assign trial = den_reg << k_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next = NUM_W'(hits) + NUM_W'(misses);
            rem_next = num;
            q_next   = '0;
            k_next   = K_W'(RATE_W - 1);
            if (den_next == '0)
            begin
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next      = rem_reg - trial;
                q_next[k_reg] = 1'b1;
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        k_reg   <= k_next;
    end

    assign done = done_reg;
    assign rate = q_reg;

endmodule

// ===== rtl/csh_back.sv =====
// ----------------------------------------------------------------------------
// csh_back
// lookup, victim choice, write-back, refill and byte access over the cache
// arrays and the backing memory; holds the response register
// ----------------------------------------------------------------------------
module csh_back #(
    parameter int WAYS        = csh_pkg::WAYS_DEF,
    parameter int SETS        = csh_pkg::SETS_DEF,
    parameter int BLOCK_BYTES = csh_pkg::BLOCK_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  csh_pkg::csh_fq_t fq,
    output csh_pkg::csh_bk_t bk,
    csh_rsp_if.source        rsp
);
    import csh_pkg::*;

    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int SETB      = $clog2(SETS);
    localparam int SI_W      = (SETB > 0) ? SETB : 1;
    localparam int WY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINES     = WAYS * SETS;
    localparam int LN_W      = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LB_DEPTH  = LINES * BLOCK_BYTES;
    localparam int LB_W      = $clog2(LB_DEPTH);
    localparam int TAG_W     = ADDR_BITS - OFF_W - SETB;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int CNT_W     = OFF_W + 1;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_LOOK   = 4'd2;
    localparam logic [3:0] ST_WB     = 4'd3;
    localparam logic [3:0] ST_RF     = 4'd4;
    localparam logic [3:0] ST_UPD    = 4'd5;
    localparam logic [3:0] ST_ACC    = 4'd6;
    localparam logic [3:0] ST_RD     = 4'd7;
    localparam logic [3:0] ST_DSTART = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    // memories
    logic [DATA_W-1:0]       bm_mem  [MEM_DEPTH];
    logic [DATA_W-1:0]       lb_mem  [LB_DEPTH];
    logic [WAYS*TAG_W-1:0]   tag_mem [SETS];
    logic [WAYS*AGE_W-1:0]   age_mem [SETS];

    logic [3:0]              state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [DATA_W-1:0]       wdata_reg;
    logic [WY_W-1:0]         way_reg;
    logic                    hit_reg, wb_reg;
    logic [DATA_W-1:0]       rdata_reg;
    logic [TAG_W-1:0]        old_tag_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ADDR_BITS-1:0]    clr_addr_reg;
    logic [COUNT_W-1:0]      hits_reg, misses_reg;
    logic [RATE_W-1:0]       rate_reg;
    logic [LINES-1:0]        valid_reg, dirty_reg;
    logic [DATA_W-1:0]       bm_rdata_reg, lb_rdata_reg;
    logic [WAYS*TAG_W-1:0]   tag_row_reg;
    logic [WAYS*AGE_W-1:0]   age_row_reg;
    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_rdata_reg;
    logic                    out_hit_reg, out_wb_reg;
    logic [COUNT_W-1:0]      out_hits_reg, out_misses_reg;
    logic [RATE_W-1:0]       out_rate_reg;

    logic                    pop, load_out;
    logic [SI_W-1:0]         in_set, set_idx;
    logic [TAG_W-1:0]        tag;
    logic [OFF_W-1:0]        off;
    logic [LN_W-1:0]         cur_line;
    logic                    found;
    logic [WY_W-1:0]         hit_way, vic_way, use_way;
    logic [AGE_W-1:0]        top_age;
    logic [WAYS*AGE_W-1:0]   age_row_new;
    logic [WAYS*TAG_W-1:0]   tag_row_new;
    logic [LN_W-1:0]         vic_line;
    logic [OFF_W-1:0]        cnt_prev;

    logic                    bm_we, bm_re;
    logic [ADDR_BITS-1:0]    bm_waddr, bm_raddr;
    logic [DATA_W-1:0]       bm_wdata;
    logic                    lb_we, lb_re;
    logic [LB_W-1:0]         lb_waddr, lb_raddr;
    logic [DATA_W-1:0]       lb_wdata;
    logic                    age_we, tag_we;
    logic [SI_W-1:0]         age_waddr;
    logic [WAYS*AGE_W-1:0]   age_wdata;
    logic                    set_valid, set_dirty, clr_dirty;
    logic                    div_start, div_done;
    logic [RATE_W-1:0]       div_rate;

    assign in_set   = SI_W'((fq.item.address >> OFF_W) % SETS);
    assign set_idx  = SI_W'((addr_reg >> OFF_W) % SETS);
    assign tag      = TAG_W'(addr_reg >> (OFF_W + SETB));
    assign off      = OFF_W'(addr_reg % BLOCK_BYTES);
    assign cur_line = LN_W'(int'(set_idx) * WAYS + int'(way_reg));
    assign cnt_prev = OFF_W'(cnt_reg - 1'b1);
    assign pop      = (state_reg == ST_IDLE) && fq.valid;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || rsp.ready);

    assign bk.pop      = pop;
    assign bk.clr_done = (state_reg != ST_CLR);

    // lookup and victim choice over the set held in the row registers
    always_comb
    begin
        found   = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[LN_W'(int'(set_idx) * WAYS + w)] &&
                tag_row_reg[w*TAG_W +: TAG_W] == tag)
            begin
                found   = 1'b1;
                hit_way = WY_W'(w);
            end
        end
        vic_way = '0;
        top_age = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (age_row_reg[w*AGE_W +: AGE_W] > top_age)
            begin
                top_age = age_row_reg[w*AGE_W +: AGE_W];
                vic_way = WY_W'(w);
            end
        end
        use_way = found ? hit_way : vic_way;
        for (int w = 0; w < WAYS; w++)
        begin
            age_row_new[w*AGE_W +: AGE_W] = (WY_W'(w) == use_way) ? '0 :
                                            age_row_reg[w*AGE_W +: AGE_W] + 1'b1;
        end
        vic_line    = LN_W'(int'(set_idx) * WAYS + int'(vic_way));
        tag_row_new = tag_row_reg;
        tag_row_new[way_reg*TAG_W +: TAG_W] = tag;
    end

    always_comb
    begin
        state_next = state_reg;
        bm_we      = 1'b0;
        bm_waddr   = '0;
        bm_wdata   = '0;
        bm_re      = 1'b0;
        bm_raddr   = '0;
        lb_we      = 1'b0;
        lb_waddr   = '0;
        lb_wdata   = '0;
        lb_re      = 1'b0;
        lb_raddr   = '0;
        age_we     = 1'b0;
        age_waddr  = set_idx;
        age_wdata  = age_row_new;
        tag_we     = 1'b0;
        set_valid  = 1'b0;
        set_dirty  = 1'b0;
        clr_dirty  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_CLR:
            begin
                bm_we     = 1'b1;
                bm_waddr  = clr_addr_reg;
                age_we    = 1'b1;
                age_waddr = SI_W'(clr_addr_reg % SETS);
                age_wdata = '0;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (fq.valid)
                begin
                    if (fq.item.cmd == CMD_READ || fq.item.cmd == CMD_WRITE)
                    begin
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_DSTART;
                        if (fq.item.cmd == CMD_PRELOAD)
                        begin
                            bm_we    = 1'b1;
                            bm_waddr = fq.item.address;
                            bm_wdata = fq.item.write_data;
                        end
                    end
                end
            end
            ST_LOOK:
            begin
                age_we = 1'b1;
                if (found)
                begin
                    state_next = ST_ACC;
                end
                else if (valid_reg[vic_line] && dirty_reg[vic_line])
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_RF;
                end
            end
            ST_WB:
            begin
                // read line byte n while byte n-1 goes to backing memory
                if (cnt_reg != CNT_W'(BLOCK_BYTES))
                begin
                    lb_re    = 1'b1;
                    lb_raddr = LB_W'(int'(cur_line) * BLOCK_BYTES + int'(cnt_reg));
                end
                else
                begin
                    state_next = ST_RF;
                end
                if (cnt_reg != '0)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = ADDR_BITS'((int'(old_tag_reg) * SETS + int'(set_idx))
                                          * BLOCK_BYTES + int'(cnt_prev));
                    bm_wdata = lb_rdata_reg;
                end
            end
            ST_RF:
            begin
                if (cnt_reg != CNT_W'(BLOCK_BYTES))
                begin
                    bm_re    = 1'b1;
                    bm_raddr = {addr_reg[ADDR_BITS-1:OFF_W], cnt_reg[OFF_W-1:0]};
                end
                else
                begin
                    state_next = ST_UPD;
                end
                if (cnt_reg != '0)
                begin
                    lb_we    = 1'b1;
                    lb_waddr = LB_W'(int'(cur_line) * BLOCK_BYTES + int'(cnt_prev));
                    lb_wdata = bm_rdata_reg;
                end
            end
            ST_UPD:
            begin
                tag_we     = 1'b1;
                set_valid  = 1'b1;
                clr_dirty  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    lb_re      = 1'b1;
                    lb_raddr   = LB_W'(int'(cur_line) * BLOCK_BYTES + int'(off));
                    state_next = ST_RD;
                end
                else
                begin
                    lb_we      = 1'b1;
                    lb_waddr   = LB_W'(int'(cur_line) * BLOCK_BYTES + int'(off));
                    lb_wdata   = wdata_reg;
                    set_dirty  = 1'b1;
                    state_next = ST_DSTART;
                end
            end
            ST_RD:
            begin
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_addr_reg  <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == ST_LOOK)
            begin
                if (found)
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
                else
                begin
                    misses_reg <= misses_reg + 1'b1;
                end
            end
            if (set_valid)
            begin
                valid_reg[cur_line] <= 1'b1;
            end
            if (clr_dirty)
            begin
                dirty_reg[cur_line] <= 1'b0;
            end
            if (set_dirty)
            begin
                dirty_reg[cur_line] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg   <= fq.item.cmd;
            addr_reg  <= fq.item.address;
            wdata_reg <= fq.item.write_data;
            hit_reg   <= 1'b0;
            wb_reg    <= 1'b0;
            rdata_reg <= '0;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg     <= found;
            way_reg     <= use_way;
            old_tag_reg <= tag_row_reg[vic_way*TAG_W +: TAG_W];
            wb_reg      <= !found && valid_reg[vic_line] && dirty_reg[vic_line];
            cnt_reg     <= '0;
        end
        else if (state_reg == ST_WB && cnt_reg == CNT_W'(BLOCK_BYTES))
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == ST_WB || state_reg == ST_RF)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == ST_RD)
        begin
            rdata_reg <= lb_rdata_reg;
        end
        if (div_done)
        begin
            rate_reg <= div_rate;
        end
        if (load_out)
        begin
            out_rdata_reg  <= rdata_reg;
            out_hit_reg    <= hit_reg;
            out_wb_reg     <= wb_reg;
            out_hits_reg   <= hits_reg;
            out_misses_reg <= misses_reg;
            out_rate_reg   <= rate_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata_reg <= bm_mem[bm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lb_we)
        begin
            lb_mem[lb_waddr] <= lb_wdata;
        end
        if (lb_re)
        begin
            lb_rdata_reg <= lb_mem[lb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[set_idx] <= tag_row_new;
        end
        if (pop)
        begin
            tag_row_reg <= tag_mem[in_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        if (pop)
        begin
            age_row_reg <= age_mem[in_set];
        end
    end

    csh_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .hits   (hits_reg),
        .misses (misses_reg),
        .done   (div_done),
        .rate   (div_rate)
    );

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = out_rdata_reg;
    assign rsp.hit               = out_hit_reg;
    assign rsp.wrote_back        = out_wb_reg;
    assign rsp.hits_total        = out_hits_reg;
    assign rsp.misses_total      = out_misses_reg;
    assign rsp.miss_rate_percent = out_rate_reg;

endmodule

// ===== tb/tb_cache_if.sv =====
// ----------------------------------------------------------------------------
// tb_cache_if
// testbench-side copies are not needed; the rtl interfaces are used directly
// ----------------------------------------------------------------------------
package tb_cache_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        hit;
        logic        wrote_back;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [6:0]  miss_rate_percent;
    } cache_word_t;
endpackage

// ===== tb/tb_set_assoc_writeback_lru_cache.sv =====
// ----------------------------------------------------------------------------
// tb_set_assoc_writeback_lru_cache
// drives reads, writes, preloads and the unused command code into the cache and checks every response
// against a behavioral model of tags, ages, dirty lines and backing memory
// ----------------------------------------------------------------------------
module tb_set_assoc_writeback_lru_cache;
    timeunit 1ns;
    timeprecision 1ps;
    import csh_pkg::*;
    import tb_cache_pkg::*;

    localparam int NWAYS = 4;
    localparam int NSETS = 64;
    localparam int NBYTES = 32;
    localparam int WATCH_LIMIT = 200000;

    class cache_scoreboard;
        logic [4:0]  tags [NSETS*NWAYS];
        logic        vld [NSETS*NWAYS];
        logic        dirty [NSETS*NWAYS];
        logic [31:0] age [NSETS*NWAYS];
        logic [7:0]  lines [NSETS*NWAYS*NBYTES];
        logic [7:0]  mem [65536];
        logic [31:0] hits;
        logic [31:0] misses;
        cache_word_t pending [$];
        int          errors;
        int          n_hit;
        int          n_wb;
        int          n_checked;

        function new();
            for (int i = 0; i < NSETS*NWAYS; i++)
            begin
                tags[i] = '0; vld[i] = 0; dirty[i] = 0; age[i] = '0;
            end
            foreach (lines[i]) lines[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            hits = '0; misses = '0; errors = 0;
            n_hit = 0; n_wb = 0; n_checked = 0;
        endfunction

        function void note_access(logic [1:0] cmd, logic [15:0] a, logic [7:0] wd);
            cache_word_t r;
            int set, way, ln, base;
            logic [4:0] tag;
            logic [31:0] top;
            logic [63:0] total;
            logic found;
            r = '0;
            set = int'(a[10:5]);
            tag = a[15:11];
            if (cmd == CMD_PRELOAD)
                mem[a] = wd;
            else if (cmd == CMD_READ || cmd == CMD_WRITE)
            begin
                found = 0;
                way = 0;
                for (int w = NWAYS-1; w >= 0; w--)
                    if (vld[set*NWAYS+w] && tags[set*NWAYS+w] == tag)
                    begin
                        found = 1; way = w;
                    end
                if (found)
                begin
                    hits++;
                    r.hit = 1;
                end
                else
                begin
                    misses++;
                    top = '0;
                    for (int w = 0; w < NWAYS; w++)
                        if (age[set*NWAYS+w] > top)
                        begin
                            top = age[set*NWAYS+w]; way = w;
                        end
                    ln = set*NWAYS + way;
                    if (vld[ln] && dirty[ln])
                    begin
                        base = {tags[ln], set[5:0], 5'd0};
                        for (int i = 0; i < NBYTES; i++)
                            mem[base+i] = lines[ln*NBYTES+i];
                        r.wrote_back = 1;
                    end
                    tags[ln] = tag;
                    base = {a[15:5], 5'd0};
                    for (int i = 0; i < NBYTES; i++)
                        lines[ln*NBYTES+i] = mem[base+i];
                    dirty[ln] = 0;
                    vld[ln] = 1;
                end
                ln = set*NWAYS + way;
                for (int w = 0; w < NWAYS; w++)
                    age[set*NWAYS+w] = (w == way) ? 32'd0 : age[set*NWAYS+w] + 32'd1;
                if (cmd == CMD_READ)
                    r.read_data = lines[ln*NBYTES+a[4:0]];
                else
                begin
                    lines[ln*NBYTES+a[4:0]] = wd;
                    dirty[ln] = 1;
                end
            end
            total = 64'(hits) + 64'(misses);
            r.hits_total = hits;
            r.misses_total = misses;
            r.miss_rate_percent = (total == 0) ? 7'd0 : 7'((64'(misses) * 100) / total);
            pending.push_back(r);
        endfunction

        function void check_word(cache_word_t got);
            cache_word_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            n_checked++;
            if (got.hit) n_hit++;
            if (got.wrote_back) n_wb++;
            if (got.read_data !== exp.read_data)
                $display("%0t: read_data exp %0h got %0h", $time, exp.read_data, got.read_data);
            if (got.hit !== exp.hit)
                $display("%0t: hit exp %0b got %0b", $time, exp.hit, got.hit);
            if (got.wrote_back !== exp.wrote_back)
                $display("%0t: wrote_back exp %0b got %0b", $time, exp.wrote_back,
                         got.wrote_back);
            if (got.hits_total !== exp.hits_total)
                $display("%0t: hits_total exp %0d got %0d", $time, exp.hits_total,
                         got.hits_total);
            if (got.misses_total !== exp.misses_total)
                $display("%0t: misses_total exp %0d got %0d", $time, exp.misses_total,
                         got.misses_total);
            if (got.miss_rate_percent !== exp.miss_rate_percent)
                $display("%0t: miss_rate_percent exp %0d got %0d", $time,
                         exp.miss_rate_percent, got.miss_rate_percent);
            if (got !== exp)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    csh_req_if req ();
    csh_rsp_if rsp ();
    cache_scoreboard sb;
    int src_idle_pct;
    int snk_stall_pct;
    int idle_cycles;
    bit timed_out;

    set_assoc_writeback_lru_cache i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_word({rsp.read_data, rsp.hit, rsp.wrote_back, rsp.hits_total,
                           rsp.misses_total, rsp.miss_rate_percent});
        rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles with no accepted word; the reset sweep stays well below the limit
    always @(posedge clk)
    begin
        if (!rst_n || !req.ready && sb.pending.size() == 0 && !req.valid)
            idle_cycles <= 0;
        else if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("set_assoc_writeback_lru_cache regression: fail");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [15:0] a, logic [7:0] wd);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.cmd <= cmd;
        req.address <= a;
        req.write_data <= wd;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_access(cmd, a, wd);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // mostly a small hot region so sets fill, evict and write back
    task automatic random_word();
        logic [1:0]  cmd;
        logic [15:0] a;
        int r;
        r = $urandom_range(99);
        cmd = (r < 45) ? CMD_READ : (r < 85) ? CMD_WRITE : (r < 97) ? CMD_PRELOAD : 2'd3;
        a = 16'($urandom);
        if ($urandom_range(99) < 80)
            a[10:8] = 3'd0;
        if ($urandom_range(99) < 50)
            a[15:13] = 3'd0;
        send_word(cmd, a, 8'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        req.valid = 0;
        req.cmd = CMD_READ;
        req.address = '0;
        req.write_data = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, all commands, unused code, eviction of dirty ways
        send_word(CMD_READ, 16'h0000, 8'h00);
        send_word(CMD_WRITE, 16'hffff, 8'hff);
        send_word(CMD_READ, 16'hffff, 8'h00);
        send_word(CMD_PRELOAD, 16'hffff, 8'h5a);
        send_word(CMD_READ, 16'hffff, 8'h00);
        send_word(2'd3, 16'h1234, 8'haa);
        send_word(CMD_PRELOAD, 16'h0801, 8'ha5);
        for (int t = 0; t < 6; t++)
            send_word(CMD_WRITE, {t[4:0], 6'd0, 5'd1}, 8'(8'h10 + t));
        for (int t = 0; t < 6; t++)
            send_word(CMD_READ, {t[4:0], 6'd0, 5'd1}, 8'h00);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
                3: begin src_idle_pct = 35; snk_stall_pct = 35; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            for (int i = 0; i < 305; i++)
                random_word();
            drain();
        end

        $display("covered %0d responses: %0d hits, %0d write-backs, over five idle phases",
                 sb.n_checked, sb.n_hit, sb.n_wb);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("set_assoc_writeback_lru_cache regression: pass");
        else
            $display("set_assoc_writeback_lru_cache regression: fail");
        $finish;
    end
endmodule
